>>> design/tthq_pkg.sv
// Package with the shared types, widths and state codes of the terrain height query block.
`default_nettype none
package tthq_pkg;
   localparam int MAX_TRIANGLES = 256;
   localparam int COORD_BITS = 32;
   localparam int TABLE_DEPTH = 3 * MAX_TRIANGLES;
   localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS = 9;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int PART_BITS = 2 * DIFF_BITS + 2;
   localparam int NUM_BITS = CROSS_BITS + DIFF_BITS + 1;
   localparam int REM_BITS = CROSS_BITS + 1;
   localparam int HGT_BITS = NUM_BITS + 2;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
   localparam int ENTRY_BITS = 3 * COORD_BITS;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic signed [HGT_BITS-1:0] HEIGHT_MAX =
      {{(HGT_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
   localparam logic signed [HGT_BITS-1:0] HEIGHT_MIN = ~HEIGHT_MAX;

   typedef struct packed {
      logic                          command;
      logic [7:0]                    triangle_slot;
      logic [1:0]                    corner;
      logic signed [COORD_BITS-1:0]  coord_x;
      logic signed [COORD_BITS-1:0]  coord_y;
      logic signed [COORD_BITS-1:0]  coord_z;
   } req_type;

   typedef struct packed {
      logic                          found;
      logic [7:0]                    hit_triangle;
      logic signed [COORD_BITS-1:0]  height;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_READ1, ST_READ2, ST_DIFF, ST_MUL, ST_EVAL, ST_NORM, ST_NSUB,
      ST_NUMMUL, ST_NUMSUM, ST_NUMADD, ST_ABS, ST_DIV, ST_FIX, ST_OUT
   } state_type;
endpackage
`default_nettype wire

>>> design/tthq_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none
module tthq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]              read_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data <= mem[read_addr];
   end
endmodule
`default_nettype wire

>>> design/terrain_triangle_height_query.sv
// Top level of the terrain triangle height query block.
//
//   channel | direction | ports                            | payload
//   --------+-----------+----------------------------------+---------------
//   req     | in        | req_valid, req_stall, req_data   | req_type
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data   | rsp_type
//   csr     | in        | csr_write_enable, csr_write_data | triangle_count
//
// A load transfer writes one corner into the corner RAM at slot*3+corner.
// A query scans the triangles in turn (three corner reads from the one RAM read port,
// differences, products, edge tests) until the first hit or the end of the count; a hit
// then adds the normal, the numerator and a divider that yields one quotient bit a cycle.
// Reset clears the control state and the count register; the corner RAM is not cleared.
// Input stalls while a query runs; a finished result waits in its own register while the
// output register still holds a stalled result, and loads never overlap a scan.
`default_nettype none
module terrain_triangle_height_query import tthq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_enable,
   input  wire logic [COUNT_BITS-1:0] csr_write_data
);
   // Control state.
   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] tri_ff, tri_in;
   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [COUNT_BITS-1:0] limit_ff, limit_in;
   logic [DIV_CNT_BITS-1:0] dcnt_ff, dcnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type res_ff, res_in;

   // Datapath registers.
   logic [ENTRY_BITS-1:0] corner0_ff, corner0_in, corner1_ff, corner1_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, pz_ff, pz_in, y0_ff, y0_in;
   logic signed [DIFF_BITS-1:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [DIFF_BITS-1:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic signed [DIFF_BITS-1:0] dx_ff, dx_in, dz_ff, dz_in;
   logic signed [DIFF_BITS-1:0] px1_ff, px1_in, pz1_ff, pz1_in;
   logic signed [DIFF_BITS-1:0] x02_ff, x02_in, z02_ff, z02_in;
   logic signed [DIFF_BITS-1:0] x21_ff, x21_in, z21_ff, z21_in;
   logic signed [DIFF_BITS-1:0] px2_ff, px2_in, pz2_ff, pz2_in;
   logic signed [PROD_BITS-1:0] p_ff [8];
   logic signed [PROD_BITS-1:0] p_in [8];
   logic signed [CROSS_BITS-1:0] ny_ff, ny_in, nx_ff, nx_in, nz_ff, nz_in;
   logic signed [PART_BITS-1:0] q_ff [4];
   logic signed [PART_BITS-1:0] q_in [4];
   logic signed [NUM_BITS-1:0] sx_ff, sx_in, sz_ff, sz_in;
   logic signed [NUM_BITS-1:0] num_ff, num_in;
   logic [NUM_BITS-1:0] nsh_ff, nsh_in, quo_ff, quo_in;
   logic [REM_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic neg_ff, neg_in;

   // Combinational helpers.
   logic accept;
   logic wr_enable;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   logic signed [COORD_BITS-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
   logic signed [CROSS_BITS-1:0] c1, c2, c3, nyc;
   logic signed [DIFF_BITS:0] nl, nh;
   logic [REM_BITS-1:0] shifted;
   logic signed [HGT_BITS-1:0] qext, qsig, y0h, hgt;
   logic [COUNT_BITS-1:0] tri_next;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Corner three is not a corner, so such a load writes nothing.
   assign wr_enable = accept && (req_data.command == CMD_LOAD) && (req_data.corner != 2'd3);
   assign wr_addr = (ADDR_BITS'(req_data.triangle_slot) << 1) +
                    ADDR_BITS'(req_data.triangle_slot) + ADDR_BITS'(req_data.corner);

   // The scan reads corner 0, 1 and 2 of the current triangle in ST_READ, ST_READ1 and ST_READ2 in turn.
   assign rd_addr = base_ff + ((state_ff == ST_READ1) ? ADDR_BITS'(1) :
                               (state_ff == ST_READ2) ? ADDR_BITS'(2) : ADDR_BITS'(0));

   // One RAM holds every corner; an entry packs x, y and z of one corner.
   tthq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock),
      .write_enable(wr_enable),
      .write_addr(wr_addr),
      .write_data({req_data.coord_x, req_data.coord_y, req_data.coord_z}),
      .read_addr(rd_addr),
      .read_data(rd_data)
   );

   assign x0 = corner0_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign y0 = corner0_ff[2*COORD_BITS-1:COORD_BITS];
   assign z0 = corner0_ff[COORD_BITS-1:0];
   assign x1 = corner1_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign y1 = corner1_ff[2*COORD_BITS-1:COORD_BITS];
   assign z1 = corner1_ff[COORD_BITS-1:0];
   assign x2 = rd_data[3*COORD_BITS-1:2*COORD_BITS];
   assign y2 = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign z2 = rd_data[COORD_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      tri_in = tri_ff;
      base_in = base_ff;
      limit_in = limit_ff;
      dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      res_in = res_ff;
      corner0_in = corner0_ff; corner1_in = corner1_ff;
      px_in = px_ff; pz_in = pz_ff; y0_in = y0_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      dx_in = dx_ff; dz_in = dz_ff;
      px1_in = px1_ff; pz1_in = pz1_ff;
      x02_in = x02_ff; z02_in = z02_ff;
      x21_in = x21_ff; z21_in = z21_ff;
      px2_in = px2_ff; pz2_in = pz2_ff;
      p_in = p_ff;
      ny_in = ny_ff; nx_in = nx_ff; nz_in = nz_ff;
      q_in = q_ff;
      sx_in = sx_ff; sz_in = sz_ff; num_in = num_ff;
      nsh_in = nsh_ff; quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      neg_in = neg_ff;

      c1 = p_ff[0] - p_ff[1];
      c2 = p_ff[2] - p_ff[3];
      c3 = p_ff[4] - p_ff[5];
      nyc = p_ff[6] - p_ff[7];
      nl = $signed({1'b0, nx_ff[DIFF_BITS-1:0]});
      nh = nx_ff[CROSS_BITS-1:DIFF_BITS];
      shifted = {rem_ff[REM_BITS-2:0], nsh_ff[NUM_BITS-1]};
      qext = $signed({2'b00, quo_ff});
      qsig = neg_ff ? -qext : qext;
      y0h = y0_ff;
      hgt = y0h - qsig;
      tri_next = tri_ff + 1'b1;

      if (csr_write_enable) begin
         count_in = csr_write_data;
      end

      // The output register empties when its transfer completes.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.command == CMD_QUERY) begin
               px_in = req_data.coord_x;
               pz_in = req_data.coord_z;
               tri_in = '0;
               base_in = '0;
               limit_in = (count_ff > COUNT_BITS'(MAX_TRIANGLES)) ?
                  COUNT_BITS'(MAX_TRIANGLES) : count_ff;
               res_in = '0;
               if (count_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // Corner 0 is addressed here; its data shows up next cycle.
            state_in = ST_READ1;
         end
         ST_READ1: begin
            corner0_in = rd_data;
            state_in = ST_READ2;
         end
         ST_READ2: begin
            corner1_in = rd_data;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            y0_in = y0;
            ax_in = x1 - x0; ay_in = y1 - y0; az_in = z1 - z0;
            bx_in = x2 - x0; by_in = y2 - y0; bz_in = z2 - z0;
            dx_in = px_ff - x0; dz_in = pz_ff - z0;
            px1_in = px_ff - x1; pz1_in = pz_ff - z1;
            x02_in = x0 - x2; z02_in = z0 - z2;
            x21_in = x2 - x1; z21_in = z2 - z1;
            px2_in = px_ff - x2; pz2_in = pz_ff - z2;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            p_in[0] = az_ff * px1_ff;
            p_in[1] = ax_ff * pz1_ff;
            p_in[2] = z02_ff * dx_ff;
            p_in[3] = x02_ff * dz_ff;
            p_in[4] = z21_ff * px2_ff;
            p_in[5] = x21_ff * pz2_ff;
            p_in[6] = az_ff * bx_ff;
            p_in[7] = ax_ff * bz_ff;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            ny_in = nyc;
            if (c1[CROSS_BITS-1] || c2[CROSS_BITS-1] || c3[CROSS_BITS-1] || nyc == '0) begin
               tri_in = tri_next;
               base_in = base_ff + ADDR_BITS'(3);
               if (tri_next >= limit_ff) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            p_in[0] = ay_ff * bz_ff;
            p_in[1] = az_ff * by_ff;
            p_in[2] = ax_ff * by_ff;
            p_in[3] = ay_ff * bx_ff;
            state_in = ST_NSUB;
         end
         ST_NSUB: begin
            nx_in = c1;
            nz_in = c2;
            state_in = ST_NUMMUL;
         end
         ST_NUMMUL: begin
            // The normal is split into a low unsigned half and a high signed half.
            q_in[0] = dx_ff * nl;
            q_in[1] = dx_ff * nh;
            q_in[2] = dz_ff * $signed({1'b0, nz_ff[DIFF_BITS-1:0]});
            q_in[3] = dz_ff * $signed(nz_ff[CROSS_BITS-1:DIFF_BITS]);
            state_in = ST_NUMSUM;
         end
         ST_NUMSUM: begin
            sx_in = (NUM_BITS'(q_ff[1]) <<< DIFF_BITS) + NUM_BITS'(q_ff[0]);
            sz_in = (NUM_BITS'(q_ff[3]) <<< DIFF_BITS) + NUM_BITS'(q_ff[2]);
            state_in = ST_NUMADD;
         end
         ST_NUMADD: begin
            num_in = sx_ff + sz_ff;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in = num_ff[NUM_BITS-1] ^ ny_ff[CROSS_BITS-1];
            nsh_in = num_ff[NUM_BITS-1] ? NUM_BITS'(-num_ff) : NUM_BITS'(num_ff);
            den_in = ny_ff[CROSS_BITS-1] ? REM_BITS'(-ny_ff) : REM_BITS'(ny_ff);
            rem_in = '0;
            quo_in = '0;
            dcnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            nsh_in = {nsh_ff[NUM_BITS-2:0], 1'b0};
            if (shifted >= den_ff) begin
               rem_in = shifted - den_ff;
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_CNT_BITS'(NUM_BITS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            res_in.found = 1'b1;
            res_in.hit_triangle = tri_ff[7:0];
            if (hgt > HEIGHT_MAX) begin
               res_in.height = HEIGHT_MAX[COORD_BITS-1:0];
            end else if (hgt < HEIGHT_MIN) begin
               res_in.height = HEIGHT_MIN[COORD_BITS-1:0];
            end else begin
               res_in.height = hgt[COORD_BITS-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // The result moves to the output register only once that register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         tri_ff <= '0;
         base_ff <= '0;
         limit_ff <= '0;
         dcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         tri_ff <= tri_in;
         base_ff <= base_in;
         limit_ff <= limit_in;
         dcnt_ff <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      res_ff <= res_in;
      corner0_ff <= corner0_in; corner1_ff <= corner1_in;
      px_ff <= px_in; pz_ff <= pz_in; y0_ff <= y0_in;
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
      dx_ff <= dx_in; dz_ff <= dz_in;
      px1_ff <= px1_in; pz1_ff <= pz1_in;
      x02_ff <= x02_in; z02_ff <= z02_in;
      x21_ff <= x21_in; z21_ff <= z21_in;
      px2_ff <= px2_in; pz2_ff <= pz2_in;
      p_ff <= p_in;
      ny_ff <= ny_in; nx_ff <= nx_in; nz_ff <= nz_in;
      q_ff <= q_in;
      sx_ff <= sx_in; sz_ff <= sz_in; num_ff <= num_in;
      nsh_ff <= nsh_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      neg_ff <= neg_in;
   end
endmodule
`default_nettype wire
